@@ hw/rtl/tftp_receive_engine_assert.svh @@
// Assertion macros for the TFTP receive engine.
// Each expects clk and arst_n in scope.
`ifndef TFTP_RECEIVE_ENGINE_ASSERT_SVH
`define TFTP_RECEIVE_ENGINE_ASSERT_SVH

// Same-cycle implication.
`define TRE_ASSERT_IMP(name, cond, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error(msg);

// Next-cycle implication.
`define TRE_ASSERT_NXT(name, cond, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

@@ hw/rtl/tre_pkg.sv @@
`timescale 1ns / 1ps
package tre_pkg;

	typedef enum logic [1:0] {
		PH_REQUEST = 2'd0,
		PH_OACK    = 2'd1,
		PH_DATA    = 2'd2,
		PH_DONE    = 2'd3
	} phase_t;

	localparam logic [15:0] OP_DATA  = 16'd3;
	localparam logic [15:0] OP_ERROR = 16'd5;
	localparam logic [15:0] OP_OACK  = 16'd6;

	localparam logic [1:0] SEND_NONE = 2'd0;
	localparam logic [1:0] SEND_RRQ  = 2'd1;
	localparam logic [1:0] SEND_ACK  = 2'd2;

	localparam logic CMD_PACKET = 1'b0;
	localparam logic CMD_TICK   = 1'b1;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 24;

	localparam logic [CFG_INDEX_W-1:0] REG_BASE_ADDRESS       = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_DEFAULT_BLOCK_SIZE = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_RETRY_LIMIT        = 2'd2;

	localparam logic [23:0] BASE_ADDRESS_RST       = 24'd0;
	localparam logic [15:0] DEFAULT_BLOCK_SIZE_RST = 16'd512;
	localparam logic [7:0]  RETRY_LIMIT_RST        = 8'd5;

	typedef struct packed {
		logic        cmd;
		logic [15:0] opcode;
		logic [15:0] block_number;
		logic [11:0] packet_len;
		logic        blksize_present;
		logic [15:0] blksize_value;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  send_kind;
		logic [15:0] ack_block;
		logic        store_valid;
		logic [23:0] store_address;
		logic [11:0] store_length;
		logic        erase_sector;
		logic        transfer_done;
		logic        retries_exhausted;
	} out_item_t;

	typedef struct packed {
		logic                   wen;
		logic [CFG_INDEX_W-1:0] index;
		logic [CFG_DATA_W-1:0]  wdata;
	} cfg_wr_t;

endpackage

@@ hw/rtl/tre_if.sv @@
`timescale 1ns / 1ps
interface tre_in_if;
	import tre_pkg::*;

	logic     valid;
	logic     ready;
	in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface tre_out_if;
	import tre_pkg::*;

	logic      valid;
	logic      ready;
	out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/tre_ctrl.sv @@
`timescale 1ns / 1ps
module tre_ctrl #(
	parameter int SECTOR_SIZE    = 4096,
	parameter int MAX_PACKET_LEN = 2048
) (
	input  logic              clk,
	input  logic              arst_n,
	input  tre_pkg::cfg_wr_t  cfg,
	input  logic              step,
	input  tre_pkg::in_item_t item,
	output tre_pkg::out_item_t result
);
	import tre_pkg::*;

	// SECTOR_SIZE is a power of two
	localparam int SECTOR_BITS = $clog2(SECTOR_SIZE);
	localparam int LEN_CMP_W   = 17;

	logic [23:0] base_address_q;
	logic [15:0] default_block_size_q;
	logic [7:0]  retry_limit_q;

	phase_t      phase_q, phase_d;
	logic [15:0] current_block_q;
	logic [15:0] previous_block_q;
	logic [15:0] active_block_size_q;
	logic [23:0] write_address_q;
	logic [7:0]  tick_count_q;

	logic [11:0] len_sat;
	logic [11:0] payload;
	logic [7:0]  tick_nxt;
	logic        live;
	logic        is_tick;
	logic        exhausted;
	logic        is_pkt;
	logic        is_oack;
	logic        is_data;
	logic        data_full;
	logic        first;
	logic        go;
	logic [15:0] prev_eff;
	logic        dup;
	logic        store;
	logic        short_blk;
	logic        send_ack;

	always_comb begin
		if ({5'd0, item.packet_len} > LEN_CMP_W'(MAX_PACKET_LEN)) begin
			len_sat = 12'(MAX_PACKET_LEN);
		end else begin
			len_sat = item.packet_len;
		end
	end

	assign payload   = len_sat - 12'd4;
	assign tick_nxt  = (tick_count_q == 8'hFF) ? tick_count_q : tick_count_q + 8'd1;
	assign live      = (phase_q != PH_DONE);
	assign is_tick   = live && (item.cmd == CMD_TICK);
	assign exhausted = tick_nxt > retry_limit_q;
	assign is_pkt    = live && (item.cmd == CMD_PACKET) && (len_sat >= 12'd2);
	assign is_oack   = is_pkt && (item.opcode == OP_OACK);
	assign is_data   = is_pkt && (item.opcode == OP_DATA);
	assign data_full = is_data && (len_sat >= 12'd4);
	assign first     = (phase_q == PH_REQUEST) || (phase_q == PH_OACK);
	assign go        = !first || (item.block_number == 16'd1);
	assign prev_eff  = first ? 16'd0 : previous_block_q;
	assign dup       = (item.block_number == prev_eff);
	assign store     = data_full && go && !dup;
	assign short_blk = {4'd0, payload} < active_block_size_q;

	// next phase
	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			PH_REQUEST, PH_OACK, PH_DATA: begin
				if (is_oack) begin
					phase_d = PH_OACK;
				end else if (data_full) begin
					phase_d = (store && short_blk) ? PH_DONE : PH_DATA;
				end
			end
			PH_DONE: begin
				phase_d = PH_DONE;
			end
			default: begin
				phase_d = phase_q;
			end
		endcase
	end

	// result
	always_comb begin
		send_ack = (is_tick && !exhausted && (phase_q != PH_REQUEST)) || is_oack
			|| (data_full && go);
		result = '0;
		if (send_ack) begin
			result.send_kind = SEND_ACK;
			result.ack_block = is_data ? item.block_number : current_block_q;
		end else if (is_tick && !exhausted) begin
			result.send_kind = SEND_RRQ;
		end
		result.retries_exhausted = is_tick && exhausted;
		if (store) begin
			result.store_valid   = 1'b1;
			result.store_address = write_address_q;
			result.store_length  = payload;
			result.erase_sector  = (write_address_q[SECTOR_BITS-1:0] == '0);
			result.transfer_done = short_blk;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_address_q       <= BASE_ADDRESS_RST;
			default_block_size_q <= DEFAULT_BLOCK_SIZE_RST;
			retry_limit_q        <= RETRY_LIMIT_RST;
			phase_q              <= PH_REQUEST;
			current_block_q      <= '0;
			previous_block_q     <= '0;
			active_block_size_q  <= DEFAULT_BLOCK_SIZE_RST;
			write_address_q      <= BASE_ADDRESS_RST;
			tick_count_q         <= '0;
		end else if (cfg.wen) begin
			unique case (cfg.index)
				REG_BASE_ADDRESS: begin
					base_address_q <= cfg.wdata;
					if (phase_q == PH_REQUEST) begin
						write_address_q <= cfg.wdata;
					end
				end
				REG_DEFAULT_BLOCK_SIZE: begin
					default_block_size_q <= cfg.wdata[15:0];
					if (phase_q == PH_REQUEST) begin
						active_block_size_q <= cfg.wdata[15:0];
					end
				end
				REG_RETRY_LIMIT: begin
					retry_limit_q <= cfg.wdata[7:0];
				end
				default: begin
				end
			endcase
		end else if (step) begin
			phase_q <= phase_d;
			if (is_tick) begin
				tick_count_q <= tick_nxt;
			end
			if (is_oack && item.blksize_present) begin
				active_block_size_q <= item.blksize_value;
			end
			if (is_data) begin
				current_block_q <= item.block_number;
			end
			if (data_full) begin
				previous_block_q <= store ? item.block_number : prev_eff;
			end
			if (store) begin
				write_address_q <= write_address_q + {12'd0, payload};
			end
		end
	end

endmodule

@@ hw/rtl/tftp_receive_engine.sv @@
`timescale 1ns / 1ps
// channel  | dir | payload      | transfer when
// item     | in  | in_item_t    | item.valid && item.ready
// result   | out | out_item_t   | result.valid && result.ready
// cfg      | in  | index, wdata | cfg_wen
//
// One item per cycle unless the result stalls; each item passes the input register, then the result register.
// Each item is decided by a few compares and one 24-bit address add.
// A stalled result holds the result register and the input register behind it.
// Reset clears the state and loads the register defaults; no clearing pass.
module tftp_receive_engine #(
	parameter int SECTOR_SIZE    = 4096,
	parameter int MAX_PACKET_LEN = 2048
) (
	input  logic                                clk,
	input  logic                                arst_n,
	tre_in_if.sink                              item,
	tre_out_if.source                           result,
	input  logic                                cfg_wen,
	input  logic [tre_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [tre_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
	import tre_pkg::*;

	`include "tftp_receive_engine_assert.svh"

	logic      valid_s1;
	in_item_t  item_s1;
	logic      valid_s2;
	out_item_t res_s2;
	out_item_t res_comb;
	logic      advance;
	logic      step;
	cfg_wr_t   cfg;

	assign advance    = !valid_s2 || result.ready;
	assign step       = valid_s1 && advance;
	assign item.ready = !valid_s1 || advance;

	assign cfg.wen   = cfg_wen;
	assign cfg.index = cfg_index;
	assign cfg.wdata = cfg_wdata;

	tre_ctrl #(
		.SECTOR_SIZE    (SECTOR_SIZE),
		.MAX_PACKET_LEN (MAX_PACKET_LEN)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.step   (step),
		.item   (item_s1),
		.result (res_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (item.ready) begin
				valid_s1 <= item.valid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			item_s1 <= item.data;
		end
		if (step) begin
			res_s2 <= res_comb;
		end
	end

	assign result.valid = valid_s2;
	assign result.data  = res_s2;

	`TRE_ASSERT_NXT(a_step_loads, step, valid_s2, "stepped item did not reach result register")
	`TRE_ASSERT_IMP(a_store_acks, valid_s2 && res_s2.store_valid,
		res_s2.send_kind == SEND_ACK, "stored block without ack")
	`TRE_ASSERT_IMP(a_done_stores, valid_s2 && res_s2.transfer_done,
		res_s2.store_valid, "done without stored block")
	`TRE_ASSERT_IMP(a_exh_quiet, valid_s2 && res_s2.retries_exhausted,
		(res_s2.send_kind == SEND_NONE) && !res_s2.store_valid, "exhausted but still sending")

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
	import tre_pkg::*;

	localparam int SECTOR_BYTES = 4096;
	localparam int MAX_PKT_LEN  = 2048;
	localparam int MAX_PAYLOAD  = MAX_PKT_LEN - 4;
	localparam int SETTLE_PAD   = 4;
	localparam int HOLD_CYCLES  = 80;
	localparam int CYCLE_LIMIT  = 200000;

	logic clk;
	logic arst_n;
	logic cfg_wen;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	tre_in_if item_ch();
	tre_out_if result_ch();

	tftp_receive_engine #(
		.SECTOR_SIZE(SECTOR_BYTES),
		.MAX_PACKET_LEN(MAX_PKT_LEN)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch),
		.result(result_ch),
		.cfg_wen(cfg_wen),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	// engine state as the testbench sees it
	logic [23:0] reg_base;
	logic [15:0] reg_default_bs;
	logic [7:0] reg_retry_limit;
	phase_t eng_phase;
	logic [15:0] eng_cur_blk;
	logic [15:0] eng_prev_blk;
	logic [15:0] eng_blk_size;
	logic [23:0] eng_addr;
	logic [7:0] eng_ticks;

	in_item_t inbound_q[$];
	out_item_t reply_q[$];

	int issued;
	int results_seen;
	int fail_count;
	int cycle_count;
	int n_stores, n_erases, n_acks, n_rrq, n_exhausted, n_done;
	int plan_bs;
	logic item_taken;
	logic tx_calm, rx_calm;
	int hold_epoch;

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic out_item_t engine_response(input in_item_t it);
		out_item_t r;
		logic [11:0] len;
		logic [11:0] payload;
		logic go;
		logic send_ack;
		r = '0;
		send_ack = 1'b0;
		len = (it.packet_len > MAX_PKT_LEN) ? 12'(MAX_PKT_LEN) : it.packet_len;
		if (eng_phase == PH_DONE) begin
			r = '0;
		end else if (it.cmd == CMD_TICK) begin
			if (eng_ticks != 8'hFF)
				eng_ticks++;
			if (eng_ticks > reg_retry_limit)
				r.retries_exhausted = 1'b1;
			else if (eng_phase == PH_REQUEST)
				r.send_kind = SEND_RRQ;
			else
				send_ack = 1'b1;
		end else if (len >= 2) begin
			if (it.opcode == OP_OACK) begin
				eng_phase = PH_OACK;
				if (it.blksize_present)
					eng_blk_size = it.blksize_value;
				send_ack = 1'b1;
			end else if (it.opcode == OP_DATA) begin
				eng_cur_blk = it.block_number;
				if (len >= 4) begin
					payload = len - 12'd4;
					go = 1'b1;
					if (eng_phase == PH_REQUEST || eng_phase == PH_OACK) begin
						eng_phase = PH_DATA;
						eng_prev_blk = '0;
						go = (eng_cur_blk == 16'd1);
					end
					if (go) begin
						send_ack = 1'b1;
						if (eng_cur_blk != eng_prev_blk) begin
							eng_prev_blk = eng_cur_blk;
							r.store_valid = 1'b1;
							r.store_address = eng_addr;
							r.store_length = payload;
							r.erase_sector = (eng_addr % SECTOR_BYTES) == 0;
							eng_addr = eng_addr + payload;
							if (payload < eng_blk_size) begin
								eng_phase = PH_DONE;
								r.transfer_done = 1'b1;
							end
						end
					end
				end
			end
		end
		if (send_ack) begin
			r.send_kind = SEND_ACK;
			r.ack_block = eng_cur_blk;
		end
		n_stores += r.store_valid;
		n_erases += r.erase_sector;
		n_acks += (r.send_kind == SEND_ACK);
		n_rrq += (r.send_kind == SEND_RRQ);
		n_exhausted += r.retries_exhausted;
		n_done += r.transfer_done;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
			fail_count++;
		end
	endtask

	// transfers sampled at the rising edge
	always @(posedge clk) begin
		out_item_t want;
		if (!arst_n) begin
			item_taken = 1'b0;
		end else begin
			item_taken = item_ch.valid && item_ch.ready;
			if (result_ch.valid && result_ch.ready) begin
				results_seen++;
				if (reply_q.size() == 0) begin
					$display("%0t ns: result 0x%0h with nothing expected", $time,
						result_ch.data);
					fail_count++;
				end else begin
					want = reply_q.pop_front();
					check_field("send_kind", want.send_kind, result_ch.data.send_kind);
					check_field("ack_block", want.ack_block, result_ch.data.ack_block);
					check_field("store_valid", want.store_valid,
						result_ch.data.store_valid);
					check_field("store_address", want.store_address,
						result_ch.data.store_address);
					check_field("store_length", want.store_length,
						result_ch.data.store_length);
					check_field("erase_sector", want.erase_sector,
						result_ch.data.erase_sector);
					check_field("transfer_done", want.transfer_done,
						result_ch.data.transfer_done);
					check_field("retries_exhausted", want.retries_exhausted,
						result_ch.data.retries_exhausted);
				end
			end
			if (item_taken)
				reply_q.push_back(engine_response(item_ch.data));
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			item_ch.valid <= 1'b0;
		end else if (!item_ch.valid || item_taken) begin
			if (inbound_q.size() != 0 && (tx_calm || $urandom_range(99) >= 14)) begin
				item_ch.data <= inbound_q.pop_front();
				item_ch.valid <= 1'b1;
			end else begin
				item_ch.valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		int hold_seen;
		int hold_left;
		if (hold_epoch != hold_seen) begin
			hold_seen = hold_epoch;
			hold_left = HOLD_CYCLES;
		end
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left--;
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= rx_calm || ($urandom_range(99) >= 14);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic push_item(input logic cmd, input logic [15:0] opcode,
			input logic [15:0] blk, input logic [11:0] len, input logic present,
			input logic [15:0] bs_value);
		in_item_t it;
		it.cmd = cmd;
		it.opcode = opcode;
		it.block_number = blk;
		it.packet_len = len;
		it.blksize_present = present;
		it.blksize_value = bs_value;
		inbound_q.push_back(it);
		issued++;
	endtask

	task automatic settle();
		wait (results_seen == issued);
		repeat (SETTLE_PAD) @(negedge clk);
	endtask

	task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_wen = 1'b1;
		cfg_index = idx;
		cfg_wdata = value;
		case (idx)
			REG_BASE_ADDRESS: begin
				reg_base = value[23:0];
				if (eng_phase == PH_REQUEST)
					eng_addr = reg_base;
			end
			REG_DEFAULT_BLOCK_SIZE: begin
				reg_default_bs = value[15:0];
				if (eng_phase == PH_REQUEST)
					eng_blk_size = reg_default_bs;
			end
			REG_RETRY_LIMIT: reg_retry_limit = value[7:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_wen = 1'b0;
	endtask

	// data packet length that never makes a short block
	function automatic logic [11:0] full_len();
		if ($urandom_range(4) == 0)
			return 12'($urandom_range(4095, plan_bs + 4));
		return 12'(plan_bs + 4);
	endfunction

	task automatic open_transfer(output logic [15:0] first_blk);
		logic present;
		present = ($urandom_range(3) != 0) || (plan_bs > MAX_PAYLOAD);
		if (present) begin
			case ($urandom_range(3))
				0: plan_bs = 0;
				1: plan_bs = $urandom_range(MAX_PAYLOAD, 8);
				default: plan_bs = 8 << $urandom_range(7);
			endcase
			push_item(CMD_PACKET, OP_OACK, 16'($urandom), 12'($urandom_range(4095, 2)),
				1'b1, 16'(plan_bs));
		end else begin
			push_item(CMD_PACKET, OP_OACK, 16'($urandom), 12'($urandom_range(4095, 2)),
				1'b0, 16'($urandom));
		end
		first_blk = ($urandom_range(9) == 0) ? 16'($urandom) : 16'd1;
	endtask

	task automatic run_transfer(input int n);
		logic [15:0] blk;
		logic [15:0] op;
		int r;
		open_transfer(blk);
		repeat (n) begin
			r = $urandom_range(99);
			if (r < 62) begin
				push_item(CMD_PACKET, OP_DATA, blk, full_len(), 1'($urandom),
					16'($urandom));
				blk++;
			end else if (r < 70) begin
				push_item(CMD_PACKET, OP_DATA, blk - 16'd1, full_len(), 1'($urandom),
					16'($urandom));
			end else if (r < 80) begin
				push_item(CMD_TICK, 16'($urandom), 16'($urandom), 12'($urandom),
					1'($urandom), 16'($urandom));
			end else if (r < 85) begin
				push_item(CMD_PACKET, OP_DATA, 16'($urandom), 12'($urandom_range(3)),
					1'($urandom), 16'($urandom));
			end else if (r < 93) begin
				op = 16'($urandom);
				if (op == OP_DATA || op == OP_OACK)
					op = OP_ERROR;
				push_item(CMD_PACKET, op, 16'($urandom), 12'($urandom), 1'($urandom),
					16'($urandom));
			end else begin
				open_transfer(blk);
			end
		end
	endtask

	initial begin
		int p;
		int pick;
		int gap;
		int chunk;
		logic [15:0] blk;
		arst_n = 1'b0;
		cfg_wen = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		item_ch.valid = 1'b0;
		item_ch.data = '0;
		result_ch.ready = 1'b0;
		tx_calm = 1'b0;
		rx_calm = 1'b0;
		hold_epoch = 0;
		reg_base = BASE_ADDRESS_RST;
		reg_default_bs = DEFAULT_BLOCK_SIZE_RST;
		reg_retry_limit = RETRY_LIMIT_RST;
		eng_phase = PH_REQUEST;
		eng_cur_blk = '0;
		eng_prev_blk = '0;
		eng_blk_size = DEFAULT_BLOCK_SIZE_RST;
		eng_addr = BASE_ADDRESS_RST;
		eng_ticks = '0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		// request phase: resend, then exhaustion with a zero limit
		push_item(CMD_TICK, '0, '0, '0, 1'b0, '0);
		settle();
		write_register(REG_RETRY_LIMIT, 24'd0);
		push_item(CMD_TICK, 16'hFFFF, 16'hFFFF, 12'hFFF, 1'b1, 16'hFFFF);
		settle();
		write_register(REG_RETRY_LIMIT, 24'd255);
		write_register(REG_BASE_ADDRESS, 24'hFFFFFF);
		write_register(REG_DEFAULT_BLOCK_SIZE, 24'd65464);
		write_register(REG_BASE_ADDRESS, 24'hFFF000);
		write_register(REG_DEFAULT_BLOCK_SIZE, 24'd8);

		push_item(CMD_PACKET, OP_DATA, 16'd1, 12'd0, 1'b0, '0);
		push_item(CMD_PACKET, OP_OACK, 16'd1, 12'd1, 1'b1, 16'd16);
		push_item(CMD_PACKET, OP_ERROR, 16'd1, 12'd4, 1'b0, '0);
		push_item(CMD_PACKET, 16'hFFFF, 16'd1, 12'hFFF, 1'b0, '0);
		push_item(CMD_PACKET, OP_DATA, 16'hFFFF, 12'd3, 1'b0, '0);
		push_item(CMD_TICK, '0, '0, '0, 1'b0, '0);
		push_item(CMD_PACKET, OP_OACK, '0, 12'hFFF, 1'b0, 16'hFFFF);
		push_item(CMD_TICK, '0, '0, '0, 1'b0, '0);
		// wrong first block, then option ack again
		push_item(CMD_PACKET, OP_DATA, 16'd2, 12'd20, 1'b0, '0);
		push_item(CMD_PACKET, OP_OACK, '0, 12'd2, 1'b1, 16'd16);
		push_item(CMD_PACKET, OP_DATA, 16'd1, 12'd2048, 1'b0, '0);
		push_item(CMD_PACKET, OP_DATA, 16'd1, 12'd2048, 1'b0, '0);
		push_item(CMD_PACKET, OP_DATA, 16'd2, 12'hFFF, 1'b0, '0);
		// crosses the top of the address space
		push_item(CMD_PACKET, OP_DATA, 16'd3, 12'd24, 1'b0, '0);
		push_item(CMD_PACKET, OP_DATA, 16'd4, 12'd3, 1'b0, '0);
		push_item(CMD_TICK, '0, '0, '0, 1'b0, '0);
		push_item(CMD_PACKET, OP_DATA, 16'd4, 12'd20, 1'b0, '0);
		// zero block size: empty payload is not short
		push_item(CMD_PACKET, OP_OACK, '0, 12'd10, 1'b1, 16'd0);
		push_item(CMD_PACKET, OP_DATA, 16'd1, 12'd4, 1'b0, '0);

		for (p = 0; p < 10; p++) begin
			settle();
			write_register(REG_BASE_ADDRESS, CFG_DATA_W'($urandom));
			write_register(REG_DEFAULT_BLOCK_SIZE, CFG_DATA_W'($urandom));
			pick = $urandom_range(2);
			write_register(REG_RETRY_LIMIT,
				CFG_DATA_W'((pick == 0) ? 0 : (pick == 1) ? 255 : $urandom_range(255)));
			tx_calm = (p == 5);
			rx_calm = (p == 5);
			if (p == 3)
				hold_epoch++;
			plan_bs = eng_blk_size;
			// bring the write address back onto a sector boundary
			if (eng_addr % SECTOR_BYTES != 0) begin
				gap = SECTOR_BYTES - (eng_addr % SECTOR_BYTES);
				plan_bs = 0;
				push_item(CMD_PACKET, OP_OACK, 16'($urandom), 12'd2, 1'b1, 16'd0);
				blk = 16'd1;
				while (gap > 0) begin
					chunk = (gap > MAX_PAYLOAD) ? MAX_PAYLOAD : gap;
					push_item(CMD_PACKET, OP_DATA, blk, 12'(chunk + 4), 1'($urandom),
						16'($urandom));
					blk++;
					gap -= chunk;
				end
			end
			run_transfer(60);
		end

		// finish a transfer with a short block; everything after is ignored
		settle();
		tx_calm = 1'b0;
		rx_calm = 1'b0;
		push_item(CMD_PACKET, OP_OACK, '0, 12'd20, 1'b1, 16'd512);
		push_item(CMD_PACKET, OP_DATA, 16'd1, 12'd516, 1'b0, '0);
		push_item(CMD_PACKET, OP_DATA, 16'd2, 12'd100, 1'b0, '0);
		repeat (24)
			push_item(1'($urandom), 16'($urandom_range(7)), 16'($urandom), 12'($urandom),
				1'($urandom), 16'($urandom));
		settle();

		if (reply_q.size() != 0) begin
			$display("%0t ns: %0d expected results never arrived", $time, reply_q.size());
			fail_count++;
		end
		$display("%0d headers and ticks: %0d blocks stored, %0d sector erases, %0d acks,",
			issued, n_stores, n_erases, n_acks);
		$display("%0d request resends, %0d ticks past the retry limit, %0d transfers done",
			n_rrq, n_exhausted, n_done);
		if (fail_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule
